FILE: design/cch_pkg.sv
`timescale 1ns / 1ps

package cch_pkg;

	localparam int MAG_W   = 16;
	localparam int OFF_W   = MAG_W + 1;
	localparam int DIFF_W  = MAG_W + 2;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int VEC_W   = PROD_W + 2;
	localparam int ANG_W   = 26;
	localparam int FRAC_W  = 16;
	localparam int DEGM_W  = ANG_W - FRAC_W;
	localparam int DEG_W   = 9;
	localparam int TAB_IW  = 5;
	localparam int CAL_W   = 16;
	localparam int IDX_W   = 1;

	localparam int ANGLE_ITERATIONS_DEF = 20;

	localparam logic signed [MAG_W-1:0] MAG_MOST_POS = 16'sh7FFF;
	localparam logic signed [MAG_W-1:0] MAG_MOST_NEG = 16'sh8000;
	localparam logic [CAL_W-1:0]        CAL_SAMPLES_RST = 16'd2000;
	localparam logic signed [ANG_W-1:0] QUARTER_TURN = 26'sd5898240;
	localparam logic [DEGM_W-1:0]       FULL_TURN = 10'd360;

	typedef enum logic [IDX_W-1:0] {
		REG_ENABLED     = 1'b0,
		REG_CAL_SAMPLES = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIFF,
		S_MUL_Y,
		S_MUL_X,
		S_START,
		S_ROT,
		S_DONE
	} seq_state_t;

	// calibration view handed to the sequencer
	typedef struct packed {
		logic                      calibrating;
		logic signed [OFF_W-1:0]   x_off;
		logic signed [OFF_W-1:0]   y_off;
		logic signed [DIFF_W-1:0]  x_span;
		logic signed [DIFF_W-1:0]  y_span;
	} cal_t;

	// atan(2^-i) in degrees, Q16, rounded to nearest
	function automatic logic signed [ANG_W-1:0] atan_q16(input logic [TAB_IW-1:0] i);
		logic signed [ANG_W-1:0] r;
		unique case (i)
			5'd0:    r = 26'sd2949120;
			5'd1:    r = 26'sd1740967;
			5'd2:    r = 26'sd919879;
			5'd3:    r = 26'sd466945;
			5'd4:    r = 26'sd234379;
			5'd5:    r = 26'sd117304;
			5'd6:    r = 26'sd58666;
			5'd7:    r = 26'sd29335;
			5'd8:    r = 26'sd14668;
			5'd9:    r = 26'sd7334;
			5'd10:   r = 26'sd3667;
			5'd11:   r = 26'sd1833;
			5'd12:   r = 26'sd917;
			5'd13:   r = 26'sd458;
			5'd14:   r = 26'sd229;
			5'd15:   r = 26'sd115;
			5'd16:   r = 26'sd57;
			5'd17:   r = 26'sd29;
			5'd18:   r = 26'sd14;
			5'd19:   r = 26'sd7;
			5'd20:   r = 26'sd4;
			5'd21:   r = 26'sd2;
			5'd22:   r = 26'sd1;
			default: r = 26'sd0;
		endcase
		return r;
	endfunction

endpackage

FILE: design/cch_calib.sv
`timescale 1ns / 1ps

module cch_calib (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 upd,
	input  logic signed [cch_pkg::MAG_W-1:0]     mag_x,
	input  logic signed [cch_pkg::MAG_W-1:0]     mag_y,
	input  logic [cch_pkg::CAL_W-1:0]            cal_samples,
	output cch_pkg::cal_t                        cal
);

	localparam int OFF_W = cch_pkg::OFF_W;
	localparam int DIFF_W = cch_pkg::DIFF_W;

	logic signed [cch_pkg::MAG_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic [cch_pkg::CAL_W-1:0]        seen_q;
	logic signed [cch_pkg::OFF_W-1:0] sum_x, sum_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= cch_pkg::MAG_MOST_POS;
			max_x_q <= cch_pkg::MAG_MOST_NEG;
			min_y_q <= cch_pkg::MAG_MOST_POS;
			max_y_q <= cch_pkg::MAG_MOST_NEG;
			seen_q  <= '0;
		end else if (upd) begin
			if (mag_x < min_x_q) min_x_q <= mag_x;
			if (mag_x > max_x_q) max_x_q <= mag_x;
			if (mag_y < min_y_q) min_y_q <= mag_y;
			if (mag_y > max_y_q) max_y_q <= mag_y;
			seen_q <= seen_q + 1'b1;
		end
	end

	assign sum_x = OFF_W'(max_x_q) + OFF_W'(min_x_q);
	assign sum_y = OFF_W'(max_y_q) + OFF_W'(min_y_q);

	// halve, rounding toward zero
	always_comb begin
		cal.calibrating = seen_q < cal_samples;
		cal.x_off  = (sum_x + $signed(OFF_W'(sum_x[OFF_W-1]))) >>> 1;
		cal.y_off  = (sum_y + $signed(OFF_W'(sum_y[OFF_W-1]))) >>> 1;
		cal.x_span = DIFF_W'(max_x_q) - DIFF_W'(min_x_q);
		cal.y_span = DIFF_W'(max_y_q) - DIFF_W'(min_y_q);
	end

endmodule

FILE: design/cch_cordic.sv
`timescale 1ns / 1ps

module cch_cordic #(
	parameter int ANGLE_ITERATIONS = cch_pkg::ANGLE_ITERATIONS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [cch_pkg::VEC_W-1:0]    x_in,
	input  logic signed [cch_pkg::VEC_W-1:0]    y_in,
	output logic                                done,
	output logic [cch_pkg::DEG_W-1:0]           heading
);

	localparam int IW = (ANGLE_ITERATIONS > 1) ? $clog2(ANGLE_ITERATIONS) : 1;
	localparam logic [IW-1:0] LAST = IW'(ANGLE_ITERATIONS - 1);
	localparam int VEC_W  = cch_pkg::VEC_W;
	localparam int ANG_W  = cch_pkg::ANG_W;
	localparam int DEGM_W = cch_pkg::DEGM_W;

	logic                     busy_q, done_q, zero_q;
	logic [IW-1:0]            iter_q;
	logic signed [VEC_W-1:0]  x_q, y_q, dx, dy;
	logic signed [ANG_W-1:0]  z_q, z_mag, t_i;
	logic [DEGM_W-1:0]        deg_mag, deg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one micro-rotation per cycle through the shared shifters
	assign dx  = y_q >>> iter_q;
	assign dy  = x_q >>> iter_q;
	assign t_i = cch_pkg::atan_q16(cch_pkg::TAB_IW'(iter_q));

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				if (y_in >= 0) begin
					x_q <= y_in;
					y_q <= -x_in;
					z_q <= cch_pkg::QUARTER_TURN;
				end else begin
					x_q <= -y_in;
					y_q <= x_in;
					z_q <= -cch_pkg::QUARTER_TURN;
				end
			end else begin
				x_q <= x_in;
				y_q <= y_in;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + t_i;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - t_i;
			end
		end
	end

	// truncate toward zero, wrap negatives into 0..359
	always_comb begin
		z_mag   = z_q[ANG_W-1] ? -z_q : z_q;
		deg_mag = z_mag[ANG_W-1:cch_pkg::FRAC_W];
		if (zero_q)
			deg = '0;
		else if (z_q[ANG_W-1] && (deg_mag != '0))
			deg = cch_pkg::FULL_TURN - deg_mag;
		else
			deg = deg_mag;
	end

	assign done    = done_q;
	assign heading = deg[cch_pkg::DEG_W-1:0];

endmodule

FILE: design/calibrated_compass_heading_top.sv
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// sample    sample_valid/sample_stall mag_x, mag_y (signed 16)
// heading   heading_valid/heading_stall heading_deg (unsigned 9)
// config    cfg_valid/cfg_ready       cfg_index (1), cfg_data (16)
//
// A heading word reaches the output register after the set-up states S_DIFF
// (offsets), S_MUL_Y and S_MUL_X (two shared-multiplier products), S_START
// (CORDIC load), the CORDIC rotations and the hand-over. The next sample is
// taken once the block is back in S_IDLE. Calibration and disabled samples
// finish in S_IDLE. sample_stall is high outside S_IDLE; a finished heading
// waits in the output register, so the next sample is taken while it is
// stalled downstream, and a later heading waits in S_DONE until the register frees up.
// Reset is asynchronous, active low; no clearing pass is needed.

module calibrated_compass_heading_top #(
	parameter int ANGLE_ITERATIONS = cch_pkg::ANGLE_ITERATIONS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  logic signed [cch_pkg::MAG_W-1:0]  mag_x,
	input  logic signed [cch_pkg::MAG_W-1:0]  mag_y,
	output logic                              heading_valid,
	input  logic                              heading_stall,
	output logic [cch_pkg::DEG_W-1:0]         heading_deg,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cch_pkg::IDX_W-1:0]         cfg_index,
	input  logic [cch_pkg::CAL_W-1:0]         cfg_data
);

	localparam int DIFF_W = cch_pkg::DIFF_W;
	localparam int VEC_W  = cch_pkg::VEC_W;

	cch_pkg::seq_state_t state_q, state_d;
	cch_pkg::cal_t       cal;

	logic                              enabled_q;
	logic [cch_pkg::CAL_W-1:0]         cal_samples_q;
	logic signed [cch_pkg::MAG_W-1:0]  mx_q, my_q;
	logic signed [DIFF_W-1:0]          dx_q, dy_q;
	logic signed [VEC_W-1:0]           xv_q, yv_q;
	logic signed [DIFF_W-1:0]          mul_a, mul_b;
	logic signed [cch_pkg::PROD_W-1:0] prod;
	logic                              accept, cal_upd, start, rot_done, out_free, load_out;
	logic [cch_pkg::DEG_W-1:0]         rot_heading;
	logic                              heading_valid_q;
	logic [cch_pkg::DEG_W-1:0]         heading_q;

	// config registers: writes must only arrive while idle; the block itself does not enforce this
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q     <= 1'b1;
			cal_samples_q <= cch_pkg::CAL_SAMPLES_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cch_pkg::cfg_reg_t'(cfg_index))
				cch_pkg::REG_ENABLED:     enabled_q     <= cfg_data[0];
				cch_pkg::REG_CAL_SAMPLES: cal_samples_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sample_stall = (state_q != cch_pkg::S_IDLE);
	assign accept       = sample_valid && !sample_stall;
	assign cal_upd      = accept && enabled_q && cal.calibrating;

	cch_calib u_calib (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (cal_upd),
		.mag_x       (mag_x),
		.mag_y       (mag_y),
		.cal_samples (cal_samples_q),
		.cal         (cal)
	);

	// hold the sample, then register the offset-removed differences and both products for the heading path
	always_ff @(posedge clk) begin
		if (accept) begin
			mx_q <= mag_x;
			my_q <= mag_y;
		end
		if (state_q == cch_pkg::S_DIFF) begin
			dx_q <= DIFF_W'(mx_q) - DIFF_W'(cal.x_off);
			dy_q <= DIFF_W'(my_q) - DIFF_W'(cal.y_off);
		end
		if (state_q == cch_pkg::S_MUL_Y)
			yv_q <= VEC_W'(prod);
		if (state_q == cch_pkg::S_MUL_X)
			xv_q <= VEC_W'(prod);
	end

	// one shared multiplier, used for Y then X
	always_comb begin
		if (state_q == cch_pkg::S_MUL_Y) begin
			mul_a = dy_q;
			mul_b = cal.x_span;
		end else begin
			mul_a = dx_q;
			mul_b = cal.y_span;
		end
	end

	assign prod = mul_a * mul_b;

	assign start = (state_q == cch_pkg::S_START);

	cch_cordic #(
		.ANGLE_ITERATIONS (ANGLE_ITERATIONS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.x_in    (xv_q),
		.y_in    (yv_q),
		.done    (rot_done),
		.heading (rot_heading)
	);

	assign out_free = !heading_valid_q || !heading_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= cch_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			cch_pkg::S_IDLE: begin
				// drop disabled samples; calibration samples finish here
				if (accept && enabled_q && !cal.calibrating)
					state_d = cch_pkg::S_DIFF;
			end
			cch_pkg::S_DIFF:  state_d = cch_pkg::S_MUL_Y;
			cch_pkg::S_MUL_Y: state_d = cch_pkg::S_MUL_X;
			cch_pkg::S_MUL_X: state_d = cch_pkg::S_START;
			cch_pkg::S_START: state_d = cch_pkg::S_ROT;
			cch_pkg::S_ROT: begin
				if (rot_done) begin
					if (out_free) begin
						load_out = 1'b1;
						state_d  = cch_pkg::S_IDLE;
					end else begin
						state_d = cch_pkg::S_DONE;
					end
				end
			end
			cch_pkg::S_DONE: begin
				// hold until the output register frees up
				if (out_free) begin
					load_out = 1'b1;
					state_d  = cch_pkg::S_IDLE;
				end
			end
			default: state_d = cch_pkg::S_IDLE;
		endcase
	end

	// output register parts the two sides
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			heading_valid_q <= 1'b0;
		else if (load_out)
			heading_valid_q <= 1'b1;
		else if (!heading_stall)
			heading_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out)
			heading_q <= rot_heading;
	end

	assign heading_valid = heading_valid_q;
	assign heading_deg   = heading_q;

endmodule

FILE: tb/sv/heading_checker.sv
`timescale 1ns / 1ps

module heading_checker #(
	parameter int ITERATIONS = cch_pkg::ANGLE_ITERATIONS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	input  logic                              sample_stall,
	input  logic signed [cch_pkg::MAG_W-1:0]  mag_x,
	input  logic signed [cch_pkg::MAG_W-1:0]  mag_y,
	input  logic                              heading_valid,
	input  logic                              heading_stall,
	input  logic [cch_pkg::DEG_W-1:0]         heading_deg,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [cch_pkg::IDX_W-1:0]         cfg_index,
	input  logic [cch_pkg::CAL_W-1:0]         cfg_data,
	output int                                mismatches,
	output int                                due_count,
	output logic [cch_pkg::CAL_W-1:0]         seen_count,
	output int                                n_samples,
	output int                                n_cal,
	output int                                n_ignored,
	output int                                n_headings
);

	localparam int STEPS = (ITERATIONS > 32) ? 32 : ITERATIONS;
	localparam longint DEG_ONE = 65536;

	typedef struct {
		logic [cch_pkg::DEG_W-1:0] deg;
		int                        tag;
	} due_heading_t;

	due_heading_t heading_due[$];

	logic                       en_q;
	logic [cch_pkg::CAL_W-1:0]  cal_q;
	logic [cch_pkg::CAL_W-1:0]  seen_q;
	int                         lo_x, hi_x, lo_y, hi_y;

	// atan(2^-i) in degrees, Q16
	function automatic longint atan_step(input int i);
		longint r;
		case (i)
			0:       r = 2949120;
			1:       r = 1740967;
			2:       r = 919879;
			3:       r = 466945;
			4:       r = 234379;
			5:       r = 117304;
			6:       r = 58666;
			7:       r = 29335;
			8:       r = 14668;
			9:       r = 7334;
			10:      r = 3667;
			11:      r = 1833;
			12:      r = 917;
			13:      r = 458;
			14:      r = 229;
			15:      r = 115;
			16:      r = 57;
			17:      r = 29;
			18:      r = 14;
			19:      r = 7;
			20:      r = 4;
			21:      r = 2;
			22:      r = 1;
			default: r = 0;
		endcase
		return r;
	endfunction

	function automatic logic [cch_pkg::DEG_W-1:0] cordic_bearing(input longint xv,
			input longint yv);
		longint x, y, z, dx, dy, t, d;
		int i;
		if (xv == 0 && yv == 0)
			return '0;
		x = xv;
		y = yv;
		z = 0;
		// fold the left half-plane into the right one
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = 90 * DEG_ONE;
			end else begin
				x = -y;
				y = t;
				z = -90 * DEG_ONE;
			end
		end
		for (i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				z = z + atan_step(i);
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - atan_step(i);
			end
		end
		d = z / DEG_ONE;
		if (d < 0)
			d = d + 360;
		if (d >= 360)
			d = d - 360;
		return d[cch_pkg::DEG_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int mx, my, xoff, yoff, xspan, yspan;
		due_heading_t w;
		if (!arst_n) begin
			heading_due.delete();
			en_q       = 1'b1;
			cal_q      = cch_pkg::CAL_SAMPLES_RST;
			seen_q     = '0;
			lo_x       = 32767;
			hi_x       = -32768;
			lo_y       = 32767;
			hi_y       = -32768;
			mismatches = 0;
			due_count  = 0;
			seen_count = '0;
			n_samples  = 0;
			n_cal      = 0;
			n_ignored  = 0;
			n_headings = 0;
		end else begin
			// retire a heading before taking this edge's sample
			if (heading_valid && !heading_stall) begin
				if (heading_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] heading %0d arrived with none due",
							$realtime, heading_deg);
				end else begin
					w = heading_due.pop_front();
					n_headings++;
					if (heading_deg !== w.deg) begin
						mismatches++;
						if (mismatches <= 10)
							$display("[%0t] heading of sample %0d: expected %0d, got %0d",
								$realtime, w.tag, w.deg, heading_deg);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					cch_pkg::REG_ENABLED:     en_q = cfg_data[0];
					cch_pkg::REG_CAL_SAMPLES: cal_q = cfg_data;
					default: ;
				endcase
			end
			if (sample_valid && !sample_stall) begin
				n_samples++;
				mx = int'(mag_x);
				my = int'(mag_y);
				if (!en_q) begin
					n_ignored++;
				end else if (seen_q < cal_q) begin
					if (mx < lo_x) lo_x = mx;
					if (mx > hi_x) hi_x = mx;
					if (my < lo_y) lo_y = my;
					if (my > hi_y) hi_y = my;
					seen_q = seen_q + 1'b1;
					n_cal++;
				end else begin
					xoff  = (hi_x + lo_x) / 2;
					yoff  = (hi_y + lo_y) / 2;
					xspan = hi_x - lo_x;
					yspan = hi_y - lo_y;
					w.deg = cordic_bearing(longint'(mx - xoff) * longint'(yspan),
						longint'(my - yoff) * longint'(xspan));
					w.tag = n_samples;
					heading_due.push_back(w);
				end
			end
			due_count  = heading_due.size();
			seen_count = seen_q;
		end
	end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	// settle time after the last expected heading: a full CORDIC pass and margin
	localparam int SETTLE     = cch_pkg::ANGLE_ITERATIONS_DEF + 6 + 14;
	localparam int STUCK_MAX  = 4000;
	localparam int HOLD_LEN   = 400;
	localparam int PHASES     = 27;
	localparam int PHASE_LEN  = 40;

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              sample_valid;
	logic                              sample_stall;
	logic signed [cch_pkg::MAG_W-1:0]  mag_x;
	logic signed [cch_pkg::MAG_W-1:0]  mag_y;
	logic                              heading_valid;
	logic                              heading_stall = 1'b0;
	logic [cch_pkg::DEG_W-1:0]         heading_deg;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [cch_pkg::IDX_W-1:0]         cfg_index;
	logic [cch_pkg::CAL_W-1:0]         cfg_data;

	int                         mismatches, due_count;
	int                         n_samples, n_cal, n_ignored, n_headings;
	logic [cch_pkg::CAL_W-1:0]  seen_count;

	// state used by the stimulus, receiver and watchdog processes
	logic  quiet = 1'b0;
	int    hold_asked = 0;
	int    hold_served = 0;
	int    hold_left = 0;
	int    writes_done = 0;
	int    stuck = 0;

	always #5 clk = ~clk;

	calibrated_compass_heading_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.mag_x         (mag_x),
		.mag_y         (mag_y),
		.heading_valid (heading_valid),
		.heading_stall (heading_stall),
		.heading_deg   (heading_deg),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	heading_checker heading_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.mag_x         (mag_x),
		.mag_y         (mag_y),
		.heading_valid (heading_valid),
		.heading_stall (heading_stall),
		.heading_deg   (heading_deg),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.due_count     (due_count),
		.seen_count    (seen_count),
		.n_samples     (n_samples),
		.n_cal         (n_cal),
		.n_ignored     (n_ignored),
		.n_headings    (n_headings)
	);

	// Receiver: stall at random about 16 percent of the time, nothing during the quiet phase,
	// and hold off for a long stretch whenever stimulus asks for one, so that
	// the output register fills and the block stalls its sample input.
	always @(negedge clk) begin
		if (!arst_n) begin
			heading_stall <= 1'b0;
		end else if (hold_left > 0) begin
			heading_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_asked != hold_served) begin
			heading_stall <= 1'b1;
			hold_served <= hold_served + 1;
			hold_left <= HOLD_LEN - 1;
		end else begin
			heading_stall <= !quiet && ($urandom_range(99) < 16);
		end
	end

	// Watchdog: end the run if no word moves on any channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && !sample_stall) || (heading_valid && !heading_stall) ||
					(cfg_valid && cfg_ready))
				stuck <= 0;
			else
				stuck <= stuck + 1;
			if (stuck >= STUCK_MAX) begin
				$display("watchdog: no word moved for %0d cycles, %0d headings still due",
					STUCK_MAX, due_count);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Offer one sample word and hold it until accepted. Entered and left just
	// after a falling edge; valid stays high between back-to-back words unless a random idle gap drops it first.
	task automatic push_sample(input logic signed [cch_pkg::MAG_W-1:0] x,
			input logic signed [cch_pkg::MAG_W-1:0] y);
		while (!quiet && $urandom_range(99) < 16) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		mag_x <= x;
		mag_y <= y;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Write a register only once the block has drained: no heading due, and
	// long enough for any calibration or ignored word to have finished.
	task automatic write_reg(input cch_pkg::cfg_reg_t idx,
			input logic [cch_pkg::CAL_W-1:0] val);
		sample_valid <= 1'b0;
		while (due_count != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		writes_done++;
	endtask

	// Mix of full-range, near-centre, near-rail and almost-zero readings.
	function automatic logic signed [cch_pkg::MAG_W-1:0] pick_mag();
		int r, v;
		r = $urandom_range(9);
		if (r < 4)
			v = $urandom;
		else if (r < 7)
			v = int'($urandom_range(4000)) - 2000;
		else if (r == 7)
			v = $urandom_range(1) ? 32767 - int'($urandom_range(3)) :
				-32768 + int'($urandom_range(3));
		else
			v = int'($urandom_range(6)) - 3;
		return v[cch_pkg::MAG_W-1:0];
	endfunction

	initial begin
		int   phase, k, seen, cal_now, new_cal;
		logic en_now, want_en, hold_phase;

		arst_n       = 1'b0;
		sample_valid = 1'b0;
		mag_x        = '0;
		mag_y        = '0;
		cfg_valid    = 1'b0;
		cfg_index    = cch_pkg::REG_ENABLED;
		cfg_data     = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Count of zero: headings at once from the reset min/max, extremes
		// and the zero vector among them.
		write_reg(cch_pkg::REG_CAL_SAMPLES, 16'd0);
		push_sample(16'sd0, 16'sd0);
		push_sample(16'sh7FFF, 16'sh7FFF);
		push_sample(16'sh8000, 16'sh8000);
		push_sample(16'sh8000, 16'sh7FFF);
		push_sample(16'sh7FFF, 16'sh8000);
		push_sample(16'sd0, -16'sd1);

		// Disabled: drop words and leave the state alone.
		write_reg(cch_pkg::REG_ENABLED, 16'd0);
		push_sample(16'sh7FFF, 16'sh8000);
		push_sample(16'sh8000, 16'sh7FFF);
		write_reg(cch_pkg::REG_ENABLED, 16'd1);

		// Two identical calibration words: zero span on both axes, heading 0.
		write_reg(cch_pkg::REG_CAL_SAMPLES, 16'd2);
		push_sample(16'sd500, -16'sd200);
		push_sample(16'sd500, -16'sd200);
		push_sample(16'sd1234, -16'sd4321);

		// Raise the count: resume calibration on the kept min/max, then hit
		// the centre and the four cardinal points.
		write_reg(cch_pkg::REG_CAL_SAMPLES, 16'd4);
		push_sample(-16'sd700, 16'sd900);
		push_sample(16'sd1300, -16'sd1100);
		push_sample(16'sd300, -16'sd100);
		push_sample(16'sd2300, -16'sd100);
		push_sample(16'sd300, 16'sd1900);
		push_sample(-16'sd1700, -16'sd100);
		push_sample(16'sd300, -16'sd2100);

		// Largest count, then lower it below the words seen to end calibration.
		write_reg(cch_pkg::REG_CAL_SAMPLES, 16'hFFFF);
		push_sample(16'sh8000, 16'sh7FFF);
		push_sample(16'sh7FFF, 16'sh8000);
		write_reg(cch_pkg::REG_CAL_SAMPLES, 16'd3);
		push_sample(16'sh7FFF, 16'sh7FFF);

		en_now  = 1'b1;
		cal_now = 3;

		// Random phases: each may pick a new calibration count and picks an enable, then
		// streams a batch of words; phase 6 runs quiet and phases 3 and 15 ask for a hold-off.
		for (phase = 0; phase < PHASES; phase++) begin
			hold_phase = (phase == 3) || (phase == 15);
			seen = int'(seen_count);
			new_cal = -1;
			k = $urandom_range(99);
			if (hold_phase || cal_now > seen + 60)
				new_cal = $urandom_range(seen, 0);
			else if (k < 30)
				new_cal = (seen + int'($urandom_range(8, 1)) > 65535) ? 65535 :
					seen + int'($urandom_range(8, 1));
			else if (k < 38)
				new_cal = 65535;
			else if (k < 55)
				new_cal = $urandom_range(seen, 0);
			if (new_cal >= 0) begin
				write_reg(cch_pkg::REG_CAL_SAMPLES, new_cal[cch_pkg::CAL_W-1:0]);
				cal_now = new_cal;
			end
			want_en = hold_phase || ($urandom_range(99) >= 10);
			if (want_en != en_now) begin
				write_reg(cch_pkg::REG_ENABLED, {15'd0, want_en});
				en_now = want_en;
			end
			quiet = (phase == 6);
			if (hold_phase)
				hold_asked++;
			for (k = 0; k < PHASE_LEN; k++)
				push_sample(pick_mag(), pick_mag());
		end
		quiet = 1'b0;

		// Drain: drop valid, wait for every heading, then let the pipe settle.
		sample_valid <= 1'b0;
		while (due_count != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);

		$display("Covered %0d samples: %0d calibration, %0d ignored while disabled, %0d headings",
			n_samples, n_cal, n_ignored, n_headings);
		$display("%0d register writes over %0d random phases, %0d long output hold-offs",
			writes_done, PHASES, hold_served);
		if (mismatches == 0 && due_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: filelist.f
design/cch_pkg.sv
design/cch_calib.sv
design/cch_cordic.sv
design/calibrated_compass_heading_top.sv
tb/sv/heading_checker.sv
tb/sv/testbench.sv
